// ===== rtl/ffa_pkg.sv =====
package ffa_pkg;

  // Heap geometry
  localparam int HEAP_UNITS = 256;
  localparam int ADDR_W     = 8;   // one entry per unit offset
  localparam int LEN_W      = 9;   // segment length, up to HEAP_UNITS
  localparam int SUM_W      = 10;  // offset plus length

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_MEMORY = 2'd1,
    ST_FREED     = 2'd2,
    ST_BAD       = 2'd3
  } status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_F_RD,
    S_F_CHKH,
    S_F_CHKN,
    S_F_PRD,
    S_F_CHKP,
    S_FIN,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic       action;
    logic [8:0] request_size;
    logic [7:0] block_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] block_offset;
    logic [1:0] merge_count;
  } out_item_t;

  // One segment descriptor
  typedef struct packed {
    logic             start;
    logic             free;
    logic [LEN_W-1:0] len;
  } seg_word_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    seg_word_t         wdata;
  } seg_req_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] wdata;
  } prev_req_t;

  localparam seg_word_t SEG_RESET0 = '{start: 1'b1, free: 1'b1, len: LEN_W'(HEAP_UNITS)};
  localparam seg_word_t SEG_EMPTY  = '{start: 1'b0, free: 1'b0, len: '0};

endpackage

// ===== rtl/ffa_seg_mem.sv =====
module ffa_seg_mem
  import ffa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  seg_req_t  req,
  output seg_word_t rdata
);

  seg_word_t mem [HEAP_UNITS];
  logic [HEAP_UNITS-1:0] written_r;
  seg_word_t mem_q_r;
  logic      hit_r;
  logic      zero_r;

  // storage, read registered
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      mem_q_r <= mem[req.raddr];
      hit_r   <= written_r[req.raddr];
      zero_r  <= (req.raddr == '0);
    end
  end

  // per-entry written flags; unwritten entries read as their reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (req.we) begin
      written_r[req.waddr] <= 1'b1;
    end
  end

  assign rdata = hit_r ? mem_q_r : (zero_r ? SEG_RESET0 : SEG_EMPTY);

endmodule

// ===== rtl/ffa_prev_mem.sv =====
module ffa_prev_mem
  import ffa_pkg::*;
(
  input  logic              clk,
  input  prev_req_t         req,
  output logic [ADDR_W-1:0] rdata
);

  logic [ADDR_W-1:0] mem [HEAP_UNITS];
  logic [ADDR_W-1:0] rdata_r;

  // back links, written before first use
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ffa_ctrl.sv =====
module ffa_ctrl
  import ffa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  output seg_req_t          seg_req,
  input  seg_word_t         seg_rdata,
  output prev_req_t         prev_req,
  input  logic [ADDR_W-1:0] prev_rdata
);

  ctrl_state_t state_r, state_nxt;

  logic              op_r, op_nxt;
  logic [LEN_W-1:0]  size_r, size_nxt;
  logic [ADDR_W-1:0] hdl_r, hdl_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic [LEN_W-1:0]  lenh_r, lenh_nxt;
  logic [ADDR_W-1:0] prevh_r, prevh_nxt;
  logic [ADDR_W-1:0] next_r, next_nxt;
  logic [1:0]        merge_r, merge_nxt;
  logic [ADDR_W-1:0] fin_saddr_r, fin_saddr_nxt;
  seg_word_t         fin_sword_r, fin_sword_nxt;
  logic              fin_pen_r, fin_pen_nxt;
  logic [ADDR_W-1:0] fin_paddr_r, fin_paddr_nxt;
  logic [ADDR_W-1:0] fin_pdata_r, fin_pdata_nxt;
  out_item_t         res_r, res_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              out_valid_r, out_valid_nxt;

  // decode of the descriptor just read
  logic             a_zero, a_fit, a_split, a_end;
  logic [SUM_W-1:0] a_sum, h_sum, np_end, mp_end;
  logic             h_bad, h_has_next, out_free;
  logic [LEN_W-1:0] merged_len;

  assign a_zero     = (seg_rdata.len == '0);
  assign a_fit      = seg_rdata.free && (seg_rdata.len >= size_r);
  assign a_split    = (seg_rdata.len > size_r);
  assign a_sum      = SUM_W'(pos_r) + SUM_W'(seg_rdata.len);
  assign a_end      = (a_sum >= SUM_W'(HEAP_UNITS));
  assign h_bad      = !seg_rdata.start || seg_rdata.free;
  assign h_sum      = SUM_W'(hdl_r) + SUM_W'(seg_rdata.len);
  assign h_has_next = (h_sum < SUM_W'(HEAP_UNITS));
  assign merged_len = seg_rdata.len + lenh_r;
  assign np_end     = SUM_W'(hdl_r) + SUM_W'(lenh_r);
  assign mp_end     = SUM_W'(prevh_r) + SUM_W'(merged_len);
  assign out_free   = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.action == ACT_FREE) begin
            state_nxt = S_F_RD;
          end else if (in_data.request_size == '0) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_A_RD;
          end
        end
      end
      S_A_RD:   state_nxt = S_A_CHK;
      S_A_CHK: begin
        if (a_zero) begin
          state_nxt = S_OUT;
        end else if (a_fit) begin
          state_nxt = S_FIN;
        end else if (a_end) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_A_RD;
        end
      end
      S_F_RD:   state_nxt = S_F_CHKH;
      S_F_CHKH: begin
        if (h_bad) begin
          state_nxt = S_OUT;
        end else if (h_has_next) begin
          state_nxt = S_F_CHKN;
        end else begin
          state_nxt = S_F_PRD;
        end
      end
      S_F_CHKN: state_nxt = S_F_PRD;
      S_F_PRD:  state_nxt = (hdl_r != '0) ? S_F_CHKP : S_FIN;
      S_F_CHKP: state_nxt = S_FIN;
      S_FIN:    state_nxt = S_OUT;
      S_OUT:    state_nxt = out_free ? S_IDLE : S_OUT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    op_nxt        = op_r;
    size_nxt      = size_r;
    hdl_nxt       = hdl_r;
    pos_nxt       = pos_r;
    lenh_nxt      = lenh_r;
    prevh_nxt     = prevh_r;
    next_nxt      = next_r;
    merge_nxt     = merge_r;
    fin_saddr_nxt = fin_saddr_r;
    fin_sword_nxt = fin_sword_r;
    fin_pen_nxt   = fin_pen_r;
    fin_paddr_nxt = fin_paddr_r;
    fin_pdata_nxt = fin_pdata_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    seg_req       = '0;
    prev_req      = '0;
    in_ready      = (state_r == S_IDLE);

    // result register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        op_nxt    = in_data.action;
        size_nxt  = in_data.request_size;
        hdl_nxt   = in_data.block_handle;
        pos_nxt   = '0;
        merge_nxt = '0;
        res_nxt   = '{status: ST_BAD, block_offset: '0, merge_count: '0};
      end
      S_A_RD: begin
        seg_req.re    = 1'b1;
        seg_req.raddr = pos_r[ADDR_W-1:0];
      end
      S_A_CHK: begin
        if (a_zero) begin
          res_nxt = '{status: ST_NO_MEMORY, block_offset: '0, merge_count: '0};
        end else if (a_fit) begin
          fin_saddr_nxt = pos_r[ADDR_W-1:0];
          fin_pen_nxt   = 1'b0;
          if (a_split) begin
            // remainder becomes a new free segment right after
            seg_req.we      = 1'b1;
            seg_req.waddr   = pos_r[ADDR_W-1:0] + size_r[ADDR_W-1:0];
            seg_req.wdata   = '{start: 1'b1, free: 1'b1, len: seg_rdata.len - size_r};
            prev_req.we     = 1'b1;
            prev_req.waddr  = pos_r[ADDR_W-1:0] + size_r[ADDR_W-1:0];
            prev_req.wdata  = pos_r[ADDR_W-1:0];
            fin_sword_nxt   = '{start: 1'b1, free: 1'b0, len: size_r};
            fin_pen_nxt     = !a_end;
            fin_paddr_nxt   = a_sum[ADDR_W-1:0];
            fin_pdata_nxt   = pos_r[ADDR_W-1:0] + size_r[ADDR_W-1:0];
          end else begin
            fin_sword_nxt = '{start: 1'b1, free: 1'b0, len: seg_rdata.len};
          end
        end else if (a_end) begin
          res_nxt = '{status: ST_NO_MEMORY, block_offset: '0, merge_count: '0};
        end else begin
          pos_nxt = a_sum[LEN_W-1:0];
        end
      end
      S_F_RD: begin
        seg_req.re     = 1'b1;
        seg_req.raddr  = hdl_r;
        prev_req.re    = 1'b1;
        prev_req.raddr = hdl_r;
      end
      S_F_CHKH: begin
        lenh_nxt  = seg_rdata.len;
        prevh_nxt = prev_rdata;
        next_nxt  = h_sum[ADDR_W-1:0];
        if (!h_bad && h_has_next) begin
          seg_req.re    = 1'b1;
          seg_req.raddr = h_sum[ADDR_W-1:0];
        end
      end
      S_F_CHKN: begin
        // absorb a free follower
        if (seg_rdata.free) begin
          lenh_nxt      = merged_len;
          merge_nxt     = 2'd1;
          seg_req.we    = 1'b1;
          seg_req.waddr = next_r;
          seg_req.wdata = '{start: 1'b0, free: 1'b0, len: seg_rdata.len};
        end
      end
      S_F_PRD: begin
        if (hdl_r != '0) begin
          seg_req.re    = 1'b1;
          seg_req.raddr = prevh_r;
        end else begin
          fin_saddr_nxt = hdl_r;
          fin_sword_nxt = '{start: 1'b1, free: 1'b1, len: lenh_r};
          fin_pen_nxt   = (np_end < SUM_W'(HEAP_UNITS));
          fin_paddr_nxt = np_end[ADDR_W-1:0];
          fin_pdata_nxt = hdl_r;
        end
      end
      S_F_CHKP: begin
        fin_saddr_nxt = hdl_r;
        if (seg_rdata.free) begin
          // fold into the free predecessor
          seg_req.we    = 1'b1;
          seg_req.waddr = prevh_r;
          seg_req.wdata = '{start: 1'b1, free: 1'b1, len: merged_len};
          merge_nxt     = merge_r + 2'd1;
          fin_sword_nxt = '{start: 1'b0, free: 1'b0, len: lenh_r};
          fin_pen_nxt   = (mp_end < SUM_W'(HEAP_UNITS));
          fin_paddr_nxt = mp_end[ADDR_W-1:0];
          fin_pdata_nxt = prevh_r;
        end else begin
          fin_sword_nxt = '{start: 1'b1, free: 1'b1, len: lenh_r};
          fin_pen_nxt   = (np_end < SUM_W'(HEAP_UNITS));
          fin_paddr_nxt = np_end[ADDR_W-1:0];
          fin_pdata_nxt = hdl_r;
        end
      end
      S_FIN: begin
        seg_req.we     = 1'b1;
        seg_req.waddr  = fin_saddr_r;
        seg_req.wdata  = fin_sword_r;
        prev_req.we    = fin_pen_r;
        prev_req.waddr = fin_paddr_r;
        prev_req.wdata = fin_pdata_r;
        if (op_r == ACT_FREE) begin
          res_nxt = '{status: ST_FREED, block_offset: hdl_r, merge_count: merge_r};
        end else begin
          res_nxt = '{status: ST_ALLOCATED, block_offset: pos_r[ADDR_W-1:0],
                      merge_count: '0};
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    size_r      <= size_nxt;
    hdl_r       <= hdl_nxt;
    pos_r       <= pos_nxt;
    lenh_r      <= lenh_nxt;
    prevh_r     <= prevh_nxt;
    next_r      <= next_nxt;
    merge_r     <= merge_nxt;
    fin_saddr_r <= fin_saddr_nxt;
    fin_sword_r <= fin_sword_nxt;
    fin_pen_r   <= fin_pen_nxt;
    fin_paddr_r <= fin_paddr_nxt;
    fin_pdata_r <= fin_pdata_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // never read and write the same descriptor in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(seg_req.we && seg_req.re && seg_req.waddr == seg_req.raddr))
    else $error("descriptor read and write collide");

  // walk pointer stays inside the heap
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_RD) |-> (pos_r < LEN_W'(HEAP_UNITS)))
    else $error("walk beyond heap");

  // only a free beat carries merges
  a_merge_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_FREED) |-> (out_data.merge_count == '0))
    else $error("merge count on non-free beat");

  // a new beat is only loaded once the previous one is gone
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("result beat overwritten");

endmodule

// ===== rtl/first_fit_heap_allocator_unit.sv =====
// First-fit heap allocator with coalescing over a 256-unit heap.
// Input channel (in_valid/in_ready/in_data): one beat is an allocate
// (action 0, request_size units) or a free (action 1, block_handle).
// Result channel (out_valid/out_ready/out_data): exactly one beat per
// input beat, in order, giving status, block offset and merge count.
// One request is handled at a time. The segment descriptors sit in a
// one-read-port memory with a registered read: an allocate walks the
// segment chain through S_A_RD and S_A_CHK for each segment visited.
// A free reads the handle, then its follower and predecessor as they
// exist; a bad handle is answered after S_F_CHKH, and a zero-size
// allocate goes straight to S_OUT. The next beat is taken from the
// cycle the result appears. A finished result is held in an output
// register, so the next request is taken while it waits; a stalled
// receiver holds back only the delivery of the following result.
// Reset (rst_n low, synchronous) empties the heap to one free segment
// at once via per-entry written flags; no clearing pass is needed.
module first_fit_heap_allocator_unit
  import ffa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  seg_req_t          seg_req;
  seg_word_t         seg_rdata;
  prev_req_t         prev_req;
  logic [ADDR_W-1:0] prev_rdata;

  ffa_seg_mem u_seg_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (seg_req),
    .rdata (seg_rdata)
  );

  ffa_prev_mem u_prev_mem (
    .clk   (clk),
    .req   (prev_req),
    .rdata (prev_rdata)
  );

  ffa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .seg_req    (seg_req),
    .seg_rdata  (seg_rdata),
    .prev_req   (prev_req),
    .prev_rdata (prev_rdata)
  );

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  first_fit_heap_allocator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // clock, 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // shadow copy of the heap chain
  int   shadow_len   [HEAP_UNITS];
  bit   shadow_free  [HEAP_UNITS];
  bit   shadow_start [HEAP_UNITS];
  int   shadow_prev  [HEAP_UNITS];

  out_item_t pending_results[$];
  int        live_handles[$];
  int        mismatches;
  int        beats_sent;
  int        beats_checked;
  int        alloc_ok;
  int        merges_seen;
  bit        calm;

  function automatic out_item_t predict_allocate(int size);
    out_item_t r;
    int        pos;
    int        len;
    r = '{status: ST_BAD, block_offset: 8'd0, merge_count: 2'd0};
    if (size == 0) return r;
    r.status = ST_NO_MEMORY;
    pos = 0;
    while (pos < HEAP_UNITS) begin
      len = shadow_len[pos];
      if (len == 0) break;
      if (shadow_free[pos] && len >= size) begin
        if (len > size) begin
          shadow_len[pos + size]   = len - size;
          shadow_free[pos + size]  = 1'b1;
          shadow_start[pos + size] = 1'b1;
          shadow_prev[pos + size]  = pos;
          if (pos + len < HEAP_UNITS) shadow_prev[pos + len] = pos + size;
          shadow_len[pos] = size;
        end
        shadow_free[pos] = 1'b0;
        r.status       = ST_ALLOCATED;
        r.block_offset = pos[7:0];
        return r;
      end
      pos += len;
    end
    return r;
  endfunction

  function automatic out_item_t predict_release(int handle);
    out_item_t r;
    int        h;
    int        nxt;
    int        p;
    int        merges;
    r = '{status: ST_BAD, block_offset: 8'd0, merge_count: 2'd0};
    h = handle;
    merges = 0;
    if (h >= HEAP_UNITS || !shadow_start[h] || shadow_free[h]) return r;
    shadow_free[h] = 1'b1;
    nxt = h + shadow_len[h];
    if (nxt < HEAP_UNITS && shadow_free[nxt]) begin
      shadow_len[h]     += shadow_len[nxt];
      shadow_start[nxt] = 1'b0;
      shadow_free[nxt]  = 1'b0;
      merges++;
    end
    if (h != 0) begin
      p = shadow_prev[h];
      if (shadow_free[p]) begin
        shadow_len[p]   += shadow_len[h];
        shadow_start[h] = 1'b0;
        shadow_free[h]  = 1'b0;
        h = p;
        merges++;
      end
    end
    nxt = h + shadow_len[h];
    if (nxt < HEAP_UNITS) shadow_prev[nxt] = h;
    r.status       = ST_FREED;
    r.block_offset = handle[7:0];
    r.merge_count  = merges[1:0];
    return r;
  endfunction

  // send one beat, with random idle before it; predict on acceptance
  task automatic send_request(action_t act, int size, int handle);
    out_item_t r;
    while (!calm && $urandom_range(0, 99) < 9) @(negedge clk);
    in_data.action       = act;
    in_data.request_size = size[8:0];
    in_data.block_handle = handle[7:0];
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (act == ACT_ALLOC) r = predict_allocate(size);
    else                  r = predict_release(handle);
    pending_results.push_back(r);
    beats_sent++;
    if (r.status == ST_ALLOCATED) begin
      live_handles.push_back(int'(r.block_offset));
      alloc_ok++;
    end
    if (r.status == ST_FREED) begin
      merges_seen += r.merge_count;
      foreach (live_handles[i])
        if (live_handles[i] == handle) begin
          live_handles.delete(i);
          break;
        end
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // receiver stalls
  always @(negedge clk)
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 9);

  // result check
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status %0d offset %0d merges %0d",
                   out_data.status, out_data.block_offset, out_data.merge_count);
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        if (out_data.status !== want.status ||
            out_data.block_offset !== want.block_offset ||
            out_data.merge_count !== want.merge_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d off %0d mc %0d, got st %0d off %0d mc %0d",
                     want.status, want.block_offset, want.merge_count,
                     out_data.status, out_data.block_offset, out_data.merge_count);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // edges of the fields and special cases
  task automatic test_directed();
    send_request(ACT_ALLOC, 0, 0);      // zero size
    send_request(ACT_ALLOC, 257, 0);    // too big
    send_request(ACT_ALLOC, 511, 255);
    send_request(ACT_ALLOC, 256, 0);    // whole heap
    send_request(ACT_ALLOC, 1, 0);      // heap full
    send_request(ACT_FREE, 0, 0);
    send_request(ACT_FREE, 0, 0);       // already free
    send_request(ACT_FREE, 511, 5);     // not a segment start
    send_request(ACT_ALLOC, 1, 0);
    send_request(ACT_ALLOC, 2, 0);
    send_request(ACT_ALLOC, 3, 0);
    send_request(ACT_ALLOC, 250, 0);    // exact fit
    send_request(ACT_FREE, 0, 1);
    send_request(ACT_FREE, 0, 0);       // merge with next
    send_request(ACT_FREE, 0, 6);       // last segment, no merge
    send_request(ACT_FREE, 0, 3);       // merge both sides
    send_request(ACT_FREE, 0, 255);
    send_request(ACT_ALLOC, 256, 0);
    send_request(ACT_FREE, 0, 0);
  endtask

  // random mix of allocates and frees
  task automatic test_random_traffic(int count);
    int sel;
    int size;
    for (int n = 0; n < count; n++) begin
      calm = (n >= count / 3 && n < count / 3 + 150);
      sel = $urandom_range(0, 99);
      if (live_handles.size() == 0 || (sel < 55 && live_handles.size() < 40)) begin
        sel = $urandom_range(0, 99);
        if (sel < 80)      size = $urandom_range(1, 24);
        else if (sel < 95) size = $urandom_range(25, 256);
        else if (sel < 98) size = $urandom_range(257, 511);
        else               size = 0;
        send_request(ACT_ALLOC, size, $urandom_range(0, 255));
      end else if (sel < 90) begin
        send_request(ACT_FREE, $urandom_range(0, 511),
                     live_handles[$urandom_range(0, live_handles.size() - 1)]);
      end else begin
        send_request(ACT_FREE, $urandom_range(0, 511), $urandom_range(0, 255));
      end
    end
    calm = 1'b0;
  endtask

  // sender holds off until all results are back
  task automatic test_drain_pause();
    for (int n = 0; n < 4; n++) begin
      send_request(ACT_ALLOC, $urandom_range(1, 8), 0);
      wait_drained();
    end
  endtask

  // fill with unit blocks, then release in two passes
  task automatic test_fill_and_release();
    while (live_handles.size() != 0)
      send_request(ACT_FREE, 0, live_handles[0]);
    for (int n = 0; n < HEAP_UNITS; n++) send_request(ACT_ALLOC, 1, 0);
    send_request(ACT_ALLOC, 1, 0);
    for (int n = 0; n < HEAP_UNITS; n += 2) send_request(ACT_FREE, 0, n);
    for (int n = 1; n < HEAP_UNITS; n += 2) send_request(ACT_FREE, 0, n);
    send_request(ACT_ALLOC, 256, 0);
    send_request(ACT_FREE, 0, 0);
  endtask

  initial begin
    int guard;
    foreach (shadow_len[i]) begin
      shadow_len[i]   = 0;
      shadow_free[i]  = 1'b0;
      shadow_start[i] = 1'b0;
      shadow_prev[i]  = 0;
    end
    shadow_len[0]   = HEAP_UNITS;
    shadow_free[0]  = 1'b1;
    shadow_start[0] = 1'b1;
    mismatches = 0;
    beats_sent = 0;
    beats_checked = 0;
    alloc_ok = 0;
    merges_seen = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_traffic(1100);
    test_drain_pause();
    test_fill_and_release();

    guard = 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (600) @(negedge clk);
    $display("sent %0d requests, checked %0d results: %0d allocations, %0d merges",
             beats_sent, beats_checked, alloc_ok, merges_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("testbench: FAIL");
    end
    $finish;
  end

  // overall limit
  initial begin
    #80ms;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("testbench: FAIL");
    $finish;
  end

endmodule
